>>> rtl/gnf_pkg.sv
`timescale 1ns / 1ps

package gnf_pkg;

  // lattice hash multipliers
  localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y    = 32'd668265263;
  localparam logic [31:0] HASH_MUL_SEED = 32'd2246822519;
  localparam logic [31:0] HASH_MUL_MIX  = 32'd1274126177;
  localparam logic [31:0] SEED_STEP     = 32'd1013;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

  localparam logic signed [21:0] FADE_C15 = 22'sd983040;
  localparam logic signed [22:0] FADE_C10 = 23'sd655360;
  localparam logic signed [17:0] SQRT2_Q16 = 18'sd92682;

  localparam logic [31:0] FREQ_ONE = 32'd4096;
  localparam int unsigned AMP_ONE  = 32768;
  localparam int unsigned RECIP_SHIFT = 46;
  localparam int unsigned DIV_STEPS   = 47;

  // register stages inside one octave lane
  localparam int unsigned OCT_STAGES = 10;

  // configuration register indexes
  localparam logic [1:0] REG_NOISE_SEED   = 2'd0;
  localparam logic [1:0] REG_OCTAVE_COUNT = 2'd1;
  localparam logic [1:0] REG_LACUNARITY   = 2'd2;
  localparam logic [1:0] REG_OCTAVE_GAIN  = 2'd3;

  localparam logic [31:0] RST_NOISE_SEED   = 32'd0;
  localparam logic [3:0]  RST_OCTAVE_COUNT = 4'd5;
  localparam logic [15:0] RST_LACUNARITY   = 16'd8192;
  localparam logic [15:0] RST_OCTAVE_GAIN  = 16'd16384;

  typedef enum logic [1:0] {
    SETUP_START,
    SETUP_OCT,
    SETUP_DIV,
    SETUP_IDLE
  } setup_state_t;

  typedef struct packed {
    logic       busy;
    logic [4:0] active;
  } setup_status_t;

  // quarter-wave sine entry k of 2^qb, q1.15, integer taylor series
  function automatic logic [16:0] sine_entry(input int unsigned k, input int unsigned qb);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic signed [63:0] acc;
    logic [63:0] val;
    t = (64'(k) * HALF_PI_Q30) >> qb;
    t2 = (t * t) >> 30;
    term = t;
    acc = $signed(t);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * t2) >> 30) / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = '0;
    val = ($unsigned(acc) + 64'd16384) >> 15;
    if (val > 64'd32768) val = 64'd32768;
    return val[16:0];
  endfunction

endpackage

>>> rtl/gradient_noise_fbm_2d.sv
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// input     in         in_valid / in_stall   point_x, point_y (signed q15.16)
// output    out        out_valid / out_stall noise_value (signed q1.15)
// config    in         cfg_wr_en             cfg_index, cfg_wr_data
//
// one beat a cycle unless set-up is busy or the output beat is held; the output path
// runs through the octave lanes (10 stages), the registered sum tree and the
// two-stage reciprocal multiply; reset and every config write start a set-up pass
// (octave tables, then a bit-serial reciprocal); in_stall is high meanwhile
// a held output beat freezes the whole pipeline; nothing is dropped or repeated

module gradient_noise_fbm_2d #(
  parameter int MAX_OCTAVES     = 8,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] noise_value,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wr_data
);
  import gnf_pkg::*;

  // amplitude grows by under 2x per octave from 1.0 in q.15
  localparam int AW = 15 + MAX_OCTAVES;
  localparam int LVL = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
  localparam int LAT = OCT_STAGES + LVL + 2;

  logic [31:0]   freq      [MAX_OCTAVES];
  logic [31:0]   seed_term [MAX_OCTAVES];
  logic [AW-1:0] amp       [MAX_OCTAVES];
  logic [31:0]   recip;
  setup_status_t status;

  logic signed [AW+16:0] weighted [MAX_OCTAVES];
  logic [LAT-1:0] vld;
  logic           en;

  // global advance: the pipeline only holds while the output beat waits
  assign en = !(out_valid && out_stall);
  assign in_stall = status.busy || !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid && !status.busy};
    end
  end

  gnf_setup #(
    .MAXO (MAX_OCTAVES),
    .AW   (AW)
  ) u_setup (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .freq        (freq),
    .seed_term   (seed_term),
    .amp         (amp),
    .recip       (recip),
    .status      (status)
  );

  // one lane per octave, all running in lockstep
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    gnf_octave #(
      .TB (TRIG_TABLE_BITS),
      .AW (AW)
    ) u_octave (
      .clk       (clk),
      .en        (en),
      .point_x   (point_x),
      .point_y   (point_y),
      .freq      (freq[i]),
      .seed_term (seed_term[i]),
      .amp       (amp[i]),
      .weighted  (weighted[i])
    );
  end

  // weighted sum and normalisation
  gnf_combine #(
    .MAXO (MAX_OCTAVES),
    .AW   (AW)
  ) u_combine (
    .clk         (clk),
    .en          (en),
    .weighted    (weighted),
    .active      (status.active),
    .recip       (recip),
    .noise_value (noise_value)
  );

`ifndef NO_ASSERTIONS
  a_reset_setup : assert property (@(posedge clk) rst |=> status.busy)
    else $error("set-up pass not started after reset");
  a_cfg_setup : assert property (@(posedge clk) disable iff (rst)
      cfg_wr_en |=> status.busy)
    else $error("set-up pass not restarted after config write");
  a_hold_freeze : assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_stall) |=> $stable(vld))
    else $error("pipeline moved while output beat held");
`endif

endmodule

>>> rtl/gnf_setup.sv
`timescale 1ns / 1ps

module gnf_setup #(
  parameter int MAXO = 8,
  parameter int AW   = 23
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_wr_data,
  output logic [31:0]           freq      [MAXO],
  output logic [31:0]           seed_term [MAXO],
  output logic [AW-1:0]         amp       [MAXO],
  output logic [31:0]           recip,
  output gnf_pkg::setup_status_t status
);
  import gnf_pkg::*;

  localparam int IW = (MAXO > 1) ? $clog2(MAXO) : 1;
  localparam int NW = AW + $clog2(MAXO) + 1;

  setup_state_t state, state_next;
  logic [31:0] noise_seed;
  logic [3:0]  octave_count;
  logic [15:0] lacunarity;
  logic [15:0] octave_gain;

  logic [5:0]    step;
  logic [31:0]   f_acc;
  logic [AW-1:0] a_acc;
  logic [31:0]   seed_acc;
  logic [NW-1:0] norm;
  logic [NW-1:0] rem;
  logic [31:0]   quot;

  logic [4:0]     active;
  logic [47:0]    f_prod;
  logic [31:0]    f_next;
  logic [AW+15:0] a_prod;
  logic [NW:0]    r2;
  logic           ge;
  logic           oct_last, div_last;

  assign active = ({1'b0, octave_count} > 5'(MAXO)) ? 5'(MAXO) : {1'b0, octave_count};
  assign f_prod = f_acc * lacunarity;
  // frequency saturates at all ones
  assign f_next = (|f_prod[47:44]) ? '1 : f_prod[43:12];
  assign a_prod = a_acc * octave_gain;
  assign r2 = {rem, (step == 6'd0)};
  assign ge = (r2 >= {1'b0, norm});
  assign oct_last = (step == 6'(MAXO - 1));
  assign div_last = (step == 6'(DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      SETUP_START: state_next = SETUP_OCT;
      SETUP_OCT:   state_next = oct_last ? SETUP_DIV : SETUP_OCT;
      SETUP_DIV:   state_next = div_last ? SETUP_IDLE : SETUP_DIV;
      SETUP_IDLE:  state_next = SETUP_IDLE;
      default:     state_next = SETUP_START;
    endcase
    if (cfg_wr_en) state_next = SETUP_START;
  end

  always_comb begin
    status.busy = (state != SETUP_IDLE);
    status.active = active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= SETUP_START;
      noise_seed   <= RST_NOISE_SEED;
      octave_count <= RST_OCTAVE_COUNT;
      lacunarity   <= RST_LACUNARITY;
      octave_gain  <= RST_OCTAVE_GAIN;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_NOISE_SEED:   noise_seed   <= cfg_wr_data;
          REG_OCTAVE_COUNT: octave_count <= cfg_wr_data[3:0];
          REG_LACUNARITY:   lacunarity   <= cfg_wr_data[15:0];
          REG_OCTAVE_GAIN:  octave_gain  <= cfg_wr_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SETUP_START: begin
        step     <= '0;
        f_acc    <= FREQ_ONE;
        a_acc    <= AW'(AMP_ONE);
        seed_acc <= noise_seed;
        norm     <= '0;
      end
      SETUP_OCT: begin
        freq[step[IW-1:0]]      <= f_acc;
        amp[step[IW-1:0]]       <= a_acc;
        seed_term[step[IW-1:0]] <= seed_acc * HASH_MUL_SEED;
        if (5'(step) < active) norm <= norm + NW'(a_acc);
        f_acc    <= f_next;
        a_acc    <= a_prod[AW+14:15];
        seed_acc <= seed_acc + SEED_STEP;
        step     <= oct_last ? '0 : step + 6'd1;
        rem      <= '0;
        quot     <= '0;
      end
      SETUP_DIV: begin
        // restoring division of 2^46 by the weight total, one bit a cycle
        rem  <= ge ? NW'(r2 - {1'b0, norm}) : r2[NW-1:0];
        quot <= {quot[30:0], ge};
        step <= step + 6'd1;
        if (div_last) recip <= (norm == '0) ? '0 : {quot[30:0], ge};
      end
      SETUP_IDLE: ;
      default: ;
    endcase
  end

endmodule

>>> rtl/gnf_octave.sv
`timescale 1ns / 1ps

module gnf_octave #(
  parameter int TB = 10,
  parameter int AW = 23
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [31:0]    point_x,
  input  logic signed [31:0]    point_y,
  input  logic [31:0]           freq,
  input  logic [31:0]           seed_term,
  input  logic [AW-1:0]         amp,
  output logic signed [AW+16:0] weighted
);
  import gnf_pkg::*;

  localparam int QB = TB - 2;
  localparam int QUARTER = 1 << QB;

  logic [16:0] sine_lut [QUARTER+1];
  for (genvar k = 0; k <= QUARTER; k++) begin : g_lut
    assign sine_lut[k] = sine_entry(k, QB);
  end

  // stage 1: scale by frequency, split lattice and fraction
  logic signed [64:0] prod_x, prod_y;
  logic [31:0] s1_cx, s1_cy;
  logic [15:0] s1_fx, s1_fy;
  assign prod_x = point_x * $signed({1'b0, freq});
  assign prod_y = point_y * $signed({1'b0, freq});
  always_ff @(posedge clk) begin
    if (en) begin
      s1_cx <= prod_x[59:28];
      s1_cy <= prod_y[59:28];
      s1_fx <= prod_x[27:12];
      s1_fy <= prod_y[27:12];
    end
  end

  // stage 2: hash products, first fade step
  logic signed [21:0] ax, ay;
  logic signed [38:0] abx, aby;
  logic signed [22:0] bx, by;
  logic [31:0] s2_mx, s2_my;
  logic [15:0] s2_fx, s2_fy;
  logic [20:0] s2_bx, s2_by;
  assign ax = 22'sd6 * $signed({6'd0, s1_fx}) - FADE_C15;
  assign ay = 22'sd6 * $signed({6'd0, s1_fy}) - FADE_C15;
  assign abx = ax * $signed({1'b0, s1_fx});
  assign aby = ay * $signed({1'b0, s1_fy});
  assign bx = 23'(abx >>> 16) + FADE_C10;
  assign by = 23'(aby >>> 16) + FADE_C10;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_mx <= s1_cx * HASH_MUL_X;
      s2_my <= s1_cy * HASH_MUL_Y;
      s2_fx <= s1_fx;
      s2_fy <= s1_fy;
      s2_bx <= bx[20:0];
      s2_by <= by[20:0];
    end
  end

  // stage 3: corner sums and first xor-shift
  // corner order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
  logic [31:0] hsum [4];
  logic [36:0] cpx, cpy;
  logic [31:0] s3_h [4];
  logic [15:0] s3_fx, s3_fy;
  logic [20:0] s3_cx, s3_cy;
  assign hsum[0] = s2_mx + s2_my + seed_term;
  assign hsum[1] = s2_mx + HASH_MUL_X + s2_my + seed_term;
  assign hsum[2] = s2_mx + s2_my + HASH_MUL_Y + seed_term;
  assign hsum[3] = s2_mx + HASH_MUL_X + s2_my + HASH_MUL_Y + seed_term;
  assign cpx = s2_bx * s2_fx;
  assign cpy = s2_by * s2_fy;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) s3_h[j] <= hsum[j] ^ (hsum[j] >> 13);
      s3_fx <= s2_fx;
      s3_fy <= s2_fy;
      s3_cx <= cpx[36:16];
      s3_cy <= cpy[36:16];
    end
  end

  // stage 4: hash mix multiply
  logic [36:0] dpx, dpy;
  logic [31:0] s4_h [4];
  logic [15:0] s4_fx, s4_fy;
  logic [20:0] s4_dx, s4_dy;
  assign dpx = s3_cx * s3_fx;
  assign dpy = s3_cy * s3_fy;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) s4_h[j] <= s3_h[j] * HASH_MUL_MIX;
      s4_fx <= s3_fx;
      s4_fy <= s3_fy;
      s4_dx <= dpx[36:16];
      s4_dy <= dpy[36:16];
    end
  end

  // stage 5: gradient from the quarter-wave table
  // lookup j: even = cos of corner j/2, odd = sin
  logic [TB-1:0]      ph   [8];
  logic [TB-2:0]      lidx [8];
  logic [16:0]        mag  [8];
  logic signed [16:0] grad [8];
  logic [36:0] spx, spy;
  logic signed [16:0] s5_g [8];
  logic [15:0] s5_fx, s5_fy;
  logic [16:0] s5_sx, s5_sy;
  for (genvar j = 0; j < 8; j++) begin : g_grad
    logic [15:0] hl;
    assign hl = s4_h[j/2][15:0] ^ s4_h[j/2][31:16];
    assign ph[j] = ((j % 2) == 0) ? hl[15 -: TB] + TB'(QUARTER) : hl[15 -: TB];
    assign lidx[j] = ph[j][QB] ? (TB-1)'(QUARTER) - {1'b0, ph[j][QB-1:0]}
                               : {1'b0, ph[j][QB-1:0]};
    assign mag[j] = sine_lut[lidx[j]];
    assign grad[j] = ph[j][QB+1] ? -$signed(mag[j]) : $signed(mag[j]);
  end
  assign spx = s4_dx * s4_fx;
  assign spy = s4_dy * s4_fy;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 8; j++) s5_g[j] <= grad[j];
      s5_fx <= s4_fx;
      s5_fy <= s4_fy;
      s5_sx <= spx[32:16];
      s5_sy <= spy[32:16];
    end
  end

  // stage 6: corner dot products
  logic signed [16:0] dxo [2];
  logic signed [16:0] dyo [2];
  logic signed [34:0] s6_dot [4];
  logic [16:0] s6_sx, s6_sy;
  assign dxo[0] = $signed({1'b0, s5_fx});
  assign dxo[1] = $signed({1'b1, s5_fx});
  assign dyo[0] = $signed({1'b0, s5_fy});
  assign dyo[1] = $signed({1'b1, s5_fy});
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s6_dot[j] <= 35'(dxo[j%2] * s5_g[2*j]) + 35'(dyo[j/2] * s5_g[2*j+1]);
      end
      s6_sx <= s5_sx;
      s6_sy <= s5_sy;
    end
  end

  // stage 7: blend along x
  logic signed [35:0] dfx0, dfx1;
  logic signed [53:0] lpx0, lpx1;
  logic signed [35:0] s7_i0, s7_i1;
  logic [16:0] s7_sy;
  assign dfx0 = 36'(s6_dot[1]) - 36'(s6_dot[0]);
  assign dfx1 = 36'(s6_dot[3]) - 36'(s6_dot[2]);
  assign lpx0 = dfx0 * $signed({1'b0, s6_sx});
  assign lpx1 = dfx1 * $signed({1'b0, s6_sx});
  always_ff @(posedge clk) begin
    if (en) begin
      s7_i0 <= 36'(s6_dot[0]) + 36'(lpx0 >>> 16);
      s7_i1 <= 36'(s6_dot[2]) + 36'(lpx1 >>> 16);
      s7_sy <= s6_sy;
    end
  end

  // stage 8: blend along y
  logic signed [36:0] dfy;
  logic signed [54:0] lpy;
  logic signed [36:0] s8_v;
  assign dfy = 37'(s7_i1) - 37'(s7_i0);
  assign lpy = dfy * $signed({1'b0, s7_sy});
  always_ff @(posedge clk) begin
    if (en) s8_v <= 37'(s7_i0) + 37'(lpy >>> 16);
  end

  // stage 9: sqrt2 scale, back to q1.15 with saturation
  logic signed [54:0] sv;
  logic signed [22:0] svs;
  logic signed [15:0] s9_v;
  assign sv = s8_v * SQRT2_Q16;
  assign svs = 23'(sv >>> 32);
  always_ff @(posedge clk) begin
    if (en) begin
      if (svs > 23'sd32767) s9_v <= 16'sh7fff;
      else if (svs < -23'sd32768) s9_v <= 16'sh8000;
      else s9_v <= svs[15:0];
    end
  end

  // stage 10: octave weight
  always_ff @(posedge clk) begin
    if (en) weighted <= s9_v * $signed({1'b0, amp});
  end

endmodule

>>> rtl/gnf_combine.sv
`timescale 1ns / 1ps

module gnf_combine #(
  parameter int MAXO = 8,
  parameter int AW   = 23
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [AW+16:0] weighted [MAXO],
  input  logic [4:0]            active,
  input  logic [31:0]           recip,
  output logic signed [15:0]    noise_value
);
  import gnf_pkg::*;

  localparam int LVL = (MAXO > 1) ? $clog2(MAXO) : 0;
  localparam int LEAVES = 1 << LVL;
  localparam int SW = AW + 17 + LVL;
  localparam int TW = SW + 34;

  logic signed [SW-1:0] tree [LVL+1][LEAVES];

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < MAXO) begin : g_used
      // octaves past the active count drop out of the sum
      assign tree[0][j] = (5'(j) < active) ? SW'(weighted[j]) : '0;
    end else begin : g_pad
      assign tree[0][j] = '0;
    end
  end

  for (genvar l = 0; l < LVL; l++) begin : g_lvl
    for (genvar j = 0; j < (LEAVES >> (l + 1)); j++) begin : g_node
      always_ff @(posedge clk) begin
        if (en) tree[l+1][j] <= tree[l][2*j] + tree[l][2*j+1];
      end
    end
  end

  // reciprocal multiply split into two 16-bit halves
  logic signed [SW+16:0] p_hi, p_lo;
  always_ff @(posedge clk) begin
    if (en) begin
      p_hi <= tree[LVL][0] * $signed({1'b0, recip[31:16]});
      p_lo <= tree[LVL][0] * $signed({1'b0, recip[15:0]});
    end
  end

  logic signed [TW-1:0] total;
  logic signed [TW-1:0] total_sh;
  assign total = (TW'(p_hi) <<< 16) + TW'(p_lo);
  assign total_sh = total >>> RECIP_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (total_sh > 32767) noise_value <= 16'sh7fff;
      else if (total_sh < -32768) noise_value <= 16'sh8000;
      else noise_value <= total_sh[15:0];
    end
  end

endmodule
